/* hdl/shift_queue_with_reverse_macros.svh */
// Assertion helpers for the shift queue; clocked on clk, off during rst.
`ifndef SHIFT_QUEUE_WITH_REVERSE_MACROS_SVH
`define SHIFT_QUEUE_WITH_REVERSE_MACROS_SVH

// same-cycle implication
`define SQR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("shift queue check failed");

// next-cycle implication
`define SQR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("shift queue check failed");

`endif

/* hdl/sqr_pkg.sv */
package sqr_pkg;

  localparam int WORD_W  = 32;
  localparam int COUNT_W = 7;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [COUNT_W-1:0]       count_t;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_REVERSE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH,
    CMD_SHIFT,
    CMD_REV_STEP,
    CMD_REV_LOAD
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    word_t     wdata;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REV,
    ST_LOAD
  } state_t;

endpackage

/* hdl/sqr_in_if.sv */
interface sqr_in_if
  import sqr_pkg::*;
;
  logic  valid;
  logic  ready;
  op_t   op;
  word_t value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

/* hdl/sqr_out_if.sv */
interface sqr_out_if
  import sqr_pkg::*;
;
  logic   valid;
  logic   ready;
  logic   ok;
  word_t  popped_value;
  word_t  front_value;
  word_t  back_value;
  count_t count;
  logic   is_empty;
  logic   is_full;

  modport source (output valid, output ok, output popped_value, output front_value,
                  output back_value, output count, output is_empty, output is_full,
                  input ready);
  modport sink   (input valid, input ok, input popped_value, input front_value,
                  input back_value, input count, input is_empty, input is_full,
                  output ready);
endinterface

/* hdl/sqr_cell.sv */
// One queue slot (q) plus one reversal scratch slot (s).
module sqr_cell
  import sqr_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      sel,      // this cell is the first free slot, one past the tail
  input  word_t     q_right,  // q of the next cell toward the tail
  input  word_t     s_left,   // s of the previous cell (q of cell 0 for cell 0)
  output word_t     q,
  output word_t     s
);

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      CMD_PUSH: begin
        if (sel) begin
          q <= ctl.wdata;
        end
      end
      CMD_SHIFT: begin
        q <= q_right;
      end
      CMD_REV_STEP: begin
        q <= q_right;
        s <= s_left;
      end
      CMD_REV_LOAD: begin
        q <= s;
      end
      default: begin
      end
    endcase
  end

endmodule

/* hdl/shift_queue_with_reverse.sv */
// Bounded queue of signed 32-bit words kept in a row of DEPTH cells, head in cell 0.
// Channels: req (op, value) in, rsp (ok, popped_value, front_value, back_value,
// count, is_empty, is_full) out; valid/ready, a word moves when both are high.
// Every accepted word yields exactly one rsp word, registered: it shows up the
// cycle after acceptance and describes the queue after the operation.
// Push, pop, clear and reverse of zero or one word act on the cell row at acceptance.
// Reverse of n >= 2 words occupies the cell row after acceptance: n steps
// that pop q words off the head into the s row of every cell, then one parallel
// load of s back into q. req.ready stays low meanwhile; the rsp word for the
// reverse is already out since its fields are known at acceptance.
// A stalled rsp (rsp.ready low) holds its word; req.ready drops until it drains.
// Reset (rst, synchronous) empties the queue and drops rsp.valid; cell
// contents are left as they are and only read once written by a push.
// count reports the low 7 bits of the occupancy.
`include "shift_queue_with_reverse_macros.svh"

module shift_queue_with_reverse
  import sqr_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input logic      clk,
  input logic      rst,
  sqr_in_if.sink   req,
  sqr_out_if.source rsp
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // cell row
  cell_ctl_t ctl;
  word_t     q [DEPTH];
  word_t     s [DEPTH];

  // control state
  state_t        state, state_next;
  logic [CW-1:0] occ, occ_next;
  logic [CW-1:0] rev_left;
  word_t         back_reg, back_reg_next;
  cell_cmd_t     idle_cmd;

  // result of the word being accepted
  logic  r_ok;
  word_t r_popped, r_front, r_back;

  logic accept, empty, full;

  assign req.ready = (state == ST_IDLE) && (!rsp.valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign empty     = (occ == '0);
  assign full      = (occ == DEPTH_C);

  // cell 0 feeds its own q into the s row, the last cell shifts in itself
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t q_r, s_l;
    if (i == DEPTH - 1) begin : g_last
      assign q_r = q[i];
    end else begin : g_mid
      assign q_r = q[i+1];
    end
    if (i == 0) begin : g_first
      assign s_l = q[0];
    end else begin : g_rest
      assign s_l = s[i-1];
    end
    sqr_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .sel     (occ == CW'(i)),
      .q_right (q_r),
      .s_left  (s_l),
      .q       (q[i]),
      .s       (s[i])
    );
  end

  // operation decode: cell command, new occupancy and result fields
  always_comb begin
    idle_cmd      = CMD_HOLD;
    occ_next      = occ;
    back_reg_next = back_reg;
    r_ok          = 1'b1;
    r_popped      = '0;
    r_front       = empty ? word_t'(0) : q[0];
    r_back        = empty ? word_t'(0) : back_reg;
    case (req.op)
      OP_PUSH: begin
        if (full) begin
          r_ok = 1'b0;
        end else begin
          idle_cmd      = CMD_PUSH;
          occ_next      = occ + CW'(1);
          back_reg_next = req.value;
          r_front       = empty ? req.value : q[0];
          r_back        = req.value;
        end
      end
      OP_POP: begin
        if (empty) begin
          r_ok = 1'b0;
        end else begin
          idle_cmd = CMD_SHIFT;
          occ_next = occ - CW'(1);
          r_popped = q[0];
          if (occ == CW'(1)) begin
            r_front = '0;
            r_back  = '0;
          end else begin
            r_front = q[1];
          end
        end
      end
      OP_REVERSE: begin
        // head and tail trade places; one word or none is left alone
        if (!empty && occ != CW'(1)) begin
          back_reg_next = q[0];
          r_front       = back_reg;
          r_back        = q[0];
        end
      end
      OP_CLEAR: begin
        occ_next = '0;
        r_front  = '0;
        r_back   = '0;
      end
      default: begin
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && req.op == OP_REVERSE && !empty && occ != CW'(1)) begin
          state_next = ST_REV;
        end
      end
      ST_REV: begin
        if (rev_left == CW'(1)) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs: what the cell row does this cycle
  always_comb begin
    ctl.wdata = req.value;
    case (state)
      ST_IDLE: ctl.cmd = accept ? idle_cmd : CMD_HOLD;
      ST_REV:  ctl.cmd = CMD_REV_STEP;
      ST_LOAD: ctl.cmd = CMD_REV_LOAD;
      default: ctl.cmd = CMD_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      occ       <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        occ       <= occ_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_REV) begin
      rev_left <= rev_left - CW'(1);
    end else if (accept) begin
      rev_left <= occ;
    end
    if (accept) begin
      back_reg         <= back_reg_next;
      rsp.ok           <= r_ok;
      rsp.popped_value <= r_popped;
      rsp.front_value  <= r_front;
      rsp.back_value   <= r_back;
      rsp.count        <= COUNT_W'(occ_next);
      rsp.is_empty     <= (occ_next == '0);
      rsp.is_full      <= (occ_next == DEPTH_C);
    end
  end

  `SQR_ASSERT_NOW(a_busy_blocks_req, state != ST_IDLE, !req.ready)
  `SQR_ASSERT_NOW(a_occ_bounded, 1'b1, occ <= DEPTH_C)
  `SQR_ASSERT_NOW(a_refused_at_edge, rsp.valid && !rsp.ok, rsp.is_full || rsp.is_empty)
  `SQR_ASSERT_NEXT(a_rev_starts, accept && req.op == OP_REVERSE && occ > CW'(1), state == ST_REV)

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps

// Self-checking bench for the shift queue. A mirror of the queue predicts the
// status word for every accepted request word. Each accepted response word is
// compared field by field against the oldest prediction.
module tb_top;
  import sqr_pkg::*;

  localparam int QDEPTH     = 64;
  localparam int RAND_WORDS = 1850;
  // long response stall, counted by the response side
  localparam int HOLD_AT    = 1200;
  localparam int HOLD_LEN   = 400;
  // response side never stalls inside this cycle window
  localparam int CALM_FROM  = 2500;
  localparam int CALM_TO    = 3000;
  // request side never idles inside this window of random words
  localparam int STEADY_LO  = 700;
  localparam int STEADY_HI  = 1000;

  // One response word as the queue reports it.
  typedef struct packed {
    logic   ok;
    word_t  popped;
    word_t  front;
    word_t  back;
    count_t count;
    logic   empty;
    logic   full;
  } qstat_t;

  // Mirror of the queue: keeps its own cells and fill level, and the
  // status words still owed by the block, oldest first.
  class queue_mirror;
    word_t  cells [QDEPTH];
    int     fill;
    qstat_t status_due [$];
    int     mismatches;
    int     op_hits [4];
    int     refused;
    int     full_hits;

    function new();
      fill       = 0;
      mismatches = 0;
      refused    = 0;
      full_hits  = 0;
      foreach (cells[i]) cells[i] = '0;
      foreach (op_hits[i]) op_hits[i] = 0;
    endfunction

    // Apply one accepted request word and queue the status it must produce.
    function void note_request(op_t op, word_t value);
      qstat_t s;
      word_t  t;
      int     lo;
      int     hi;
      s    = '0;
      s.ok = 1'b1;
      op_hits[op]++;
      case (op)
        OP_PUSH: begin
          if (fill >= QDEPTH) begin
            s.ok = 1'b0;
          end else begin
            cells[fill] = value;
            fill++;
          end
        end
        OP_POP: begin
          if (fill == 0) begin
            s.ok = 1'b0;
          end else begin
            s.popped = cells[0];
            for (int i = 0; i + 1 < fill; i++) cells[i] = cells[i + 1];
            fill--;
          end
        end
        OP_REVERSE: begin
          lo = 0;
          hi = fill - 1;
          while (lo < hi) begin
            t         = cells[lo];
            cells[lo] = cells[hi];
            cells[hi] = t;
            lo++;
            hi--;
          end
        end
        default: begin
          fill = 0;
        end
      endcase
      if (!s.ok) refused++;
      if (fill == QDEPTH) full_hits++;
      s.front = (fill != 0) ? cells[0] : '0;
      s.back  = (fill != 0) ? cells[fill - 1] : '0;
      s.count = count_t'(fill);
      s.empty = (fill == 0);
      s.full  = (fill == QDEPTH);
      status_due.push_back(s);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_response(qstat_t got);
      qstat_t want;
      if (status_due.size() == 0) begin
        $display("%0t: response word with none expected, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = status_due.pop_front();
      compare_field("ok",           32'(want.ok),    32'(got.ok));
      compare_field("popped_value", want.popped,     got.popped);
      compare_field("front_value",  want.front,      got.front);
      compare_field("back_value",   want.back,       got.back);
      compare_field("count",        32'(want.count), 32'(got.count));
      compare_field("is_empty",     32'(want.empty), 32'(got.empty));
      compare_field("is_full",      32'(want.full),  32'(got.full));
    endfunction

    function int pending();
      return status_due.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  sqr_in_if  req ();
  sqr_out_if rsp ();

  shift_queue_with_reverse #(.DEPTH(QDEPTH)) uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  queue_mirror mirror = new();
  bit          sender_may_idle = 1'b1;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #1000000;
    $display("timeout at %0t", $time);
    $display("CHECK FAILED");
    $finish;
  end

  // Random payload, with the sign and all-ones corners showing up often.
  function automatic word_t pick_value();
    case ($urandom_range(11))
      0:       return word_t'(32'h8000_0000);
      1:       return word_t'(32'h7FFF_FFFF);
      2:       return word_t'(32'hFFFF_FFFF);
      3:       return '0;
      default: return word_t'($urandom);
    endcase
  endfunction

  // Offer one request word and hold it until the block takes it. Random idle
  // cycles go in front of the word unless the sender is in a steady stretch.
  task automatic send_word(op_t op, word_t value);
    while (sender_may_idle && $urandom_range(99) < 26) begin
      req.valid <= 1'b0;
      req.op    <= op_t'($urandom_range(3));
      req.value <= word_t'($urandom);
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.op    <= op;
    req.value <= value;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    mirror.note_request(op, value);
  endtask

  // Request side: reset, directed words, then random bursts.
  initial begin : stimulus
    int   n_rand;
    int   mode;
    int   burst;
    int   r;
    op_t  op;
    rst       <= 1'b1;
    req.valid <= 1'b0;
    req.op    <= OP_PUSH;
    req.value <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: refused pop on empty, reverse of nothing and of one word,
    // value extremes, a multi-word reverse, clear and its aftermath.
    send_word(OP_POP,     '0);
    send_word(OP_REVERSE, '0);
    send_word(OP_PUSH,    word_t'(32'h8000_0000));
    send_word(OP_REVERSE, word_t'(32'h1234_5678));
    send_word(OP_PUSH,    word_t'(32'h7FFF_FFFF));
    send_word(OP_PUSH,    '0);
    send_word(OP_PUSH,    word_t'(32'hFFFF_FFFF));
    send_word(OP_PUSH,    word_t'(32'h5555_5555));
    send_word(OP_PUSH,    word_t'(32'hAAAA_AAAA));
    send_word(OP_REVERSE, '0);
    send_word(OP_POP,     word_t'(32'hDEAD_BEEF));
    send_word(OP_POP,     '0);
    send_word(OP_REVERSE, '0);
    send_word(OP_POP,     '0);
    send_word(OP_CLEAR,   word_t'(32'hFFFF_FFFF));
    send_word(OP_POP,     '0);
    send_word(OP_PUSH,    word_t'(32'h0000_0001));
    send_word(OP_PUSH,    word_t'(32'hFFFF_FFFE));
    send_word(OP_CLEAR,   '0);
    send_word(OP_CLEAR,   '0);
    send_word(OP_REVERSE, '0);
    send_word(OP_PUSH,    word_t'(32'hCAFE_F00D));

    // Random part. Long push bursts reach full (and refused pushes), long pop
    // bursts drain to empty (and refused pops); reverses land at varied fill
    // levels along the way. Mixed and noise bursts cover the rest.
    n_rand = 0;
    while (n_rand < RAND_WORDS) begin
      mode = $urandom_range(99);
      if (mode < 30) begin
        burst = $urandom_range(70, 5);
      end else if (mode < 55) begin
        burst = $urandom_range(70, 5);
      end else if (mode < 85) begin
        burst = $urandom_range(30, 5);
      end else begin
        burst = $urandom_range(12, 2);
      end
      for (int k = 0; k < burst; k++) begin
        sender_may_idle = !(n_rand >= STEADY_LO && n_rand < STEADY_HI);
        r = $urandom_range(99);
        if (mode < 30) begin
          op = (r < 9) ? OP_REVERSE : OP_PUSH;
        end else if (mode < 55) begin
          op = (r < 9) ? OP_REVERSE : OP_POP;
        end else if (mode < 85) begin
          if (r < 42) op = OP_PUSH;
          else if (r < 80) op = OP_POP;
          else if (r < 96) op = OP_REVERSE;
          else op = OP_CLEAR;
        end else begin
          op = op_t'($urandom_range(3));
        end
        send_word(op, pick_value());
        n_rand++;
      end
    end
    req.valid <= 1'b0;

    // Drain, then give a full-depth reverse time to finish before closing.
    while (mirror.pending() != 0) @(posedge clk);
    repeat (QDEPTH + 8) @(posedge clk);

    $display("Run: %0d push, %0d pop, %0d reverse, %0d clear words checked",
             mirror.op_hits[OP_PUSH], mirror.op_hits[OP_POP],
             mirror.op_hits[OP_REVERSE], mirror.op_hits[OP_CLEAR]);
    $display("Run: %0d refused, queue at full depth after %0d words, %0d mismatches",
             mirror.refused, mirror.full_hits, mirror.mismatches);
    if (mirror.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Response side: random stalls, one long hold-off that backs the block up
  // while requests keep coming, and a window with no stalls at all.
  initial begin : response_sink
    int cyc;
    cyc = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == HOLD_AT) begin
        rsp.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        cyc += HOLD_LEN;
      end
      if (cyc >= CALM_FROM && cyc < CALM_TO) begin
        rsp.ready <= 1'b1;
      end else begin
        rsp.ready <= ($urandom_range(99) >= 26);
      end
    end
  end

  // Response monitor: a word moves when valid and ready are both high.
  initial begin : response_monitor
    qstat_t got;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        got.ok     = rsp.ok;
        got.popped = rsp.popped_value;
        got.front  = rsp.front_value;
        got.back   = rsp.back_value;
        got.count  = rsp.count;
        got.empty  = rsp.is_empty;
        got.full   = rsp.is_full;
        mirror.check_response(got);
      end
    end
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/sqr_pkg.sv
hdl/sqr_in_if.sv
hdl/sqr_out_if.sv
hdl/sqr_cell.sv
hdl/shift_queue_with_reverse.sv
bench/tb_top.sv
